/* rtl/ycmnd_pkg.sv */
// Shared types and constants for the YIN normalized-difference threshold block.
// Used by the controller, the datapath and the top level.
package ycmnd_pkg;

   // Frame and field sizes.
   localparam int MAX_LAGS  = 1024;
   localparam int LAG_W     = 10;
   localparam int CNT_W     = $clog2(MAX_LAGS + 1);
   localparam int DATA_W    = 32;
   localparam int THRESH_W  = 16;
   localparam int SUM_W     = 42;
   localparam int PROD_W    = LAG_W + DATA_W;
   localparam int FRAC_W    = 16;

   // Divider sizing: one quotient bit per cycle.
   localparam int DIV_STEPS = DATA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(13107);
   localparam logic [DATA_W-1:0]   NORM_SAT     = '1;
   localparam logic [SUM_W-1:0]    SUM_MAX      = '1;

   // Search progress within one frame.
   typedef enum logic [1:0] {
      PH_SEARCHING,
      PH_DESCENDING,
      PH_DONE
   } phase_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_EVAL,
      ST_FINISH,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic check;
      logic div_step;
      logic eval;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic overflow;
      logic last;
      logic out_free;
   } status_type;

endpackage

/* rtl/ycmnd_ctrl.sv */
// Controller state machine for the YIN normalized-difference threshold block.
// Depends on ycmnd_pkg for the state enum and the command and status structs.
module ycmnd_ctrl
   import ycmnd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 div_last;

   assign div_last = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // State and divide step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // Next state.
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            div_cnt_in = '0;
            if (!status.need_div) begin
               state_in = ST_FINISH;
            end else if (status.overflow) begin
               state_in = ST_EVAL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = status.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.check    = (state_ff == ST_CHECK) && status.need_div;
      cmd.div_step = (state_ff == ST_DIV);
      cmd.eval     = (state_ff == ST_EVAL);
      cmd.emit     = (state_ff == ST_EMIT) && status.out_free;
   end

endmodule

/* rtl/ycmnd_dp.sv */
// Datapath for the YIN normalized-difference threshold block: running sum,
// lag times difference product, restoring divider, lag search and result register.
// Depends on ycmnd_pkg for sizes, the phase enum and the command and status structs.
module ycmnd_dp
   import ycmnd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [DATA_W-1:0]   req_difference_value,
   input  logic                req_last_lag,
   input  logic                csr_write_enable,
   input  logic [THRESH_W-1:0] csr_write_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic [LAG_W-1:0]    rsp_lag,
   output logic [DATA_W-1:0]   rsp_norm_value
);

   // Configuration and frame state.
   logic [THRESH_W-1:0] thresh_ff;
   logic [CNT_W-1:0]    lag_cnt_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   phase_type           phase_ff, phase_in;
   logic [LAG_W-1:0]    best_lag_ff, best_lag_in;
   logic [DATA_W-1:0]   best_norm_ff, best_norm_in;

   // Per-request working registers.
   logic [LAG_W-1:0]    cur_lag_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                need_div_ff;
   logic                last_ff;
   logic                sat_ff;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]   quo_ff, quo_in;

   // Result register.
   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [LAG_W-1:0]    rsp_lag_ff;
   logic [DATA_W-1:0]   rsp_norm_ff;

   logic                active;
   logic [SUM_W:0]      sum_add;
   logic [SUM_W:0]      rem_shift;
   logic                rem_ge;
   logic                overflow;
   logic [DATA_W-1:0]   norm;

   assign active = (lag_cnt_ff < CNT_W'(MAX_LAGS));

   // Saturating running sum.
   assign sum_add = {1'b0, sum_ff} + {{(SUM_W + 1 - DATA_W){1'b0}}, req_difference_value};
   assign sum_in  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

   // Quotient of 2^16 or more, or a zero sum, saturates the normalized value.
   assign overflow = ({{(SUM_W - (PROD_W - FRAC_W)){1'b0}}, prod_ff[PROD_W-1:FRAC_W]} >= sum_ff);

   // One restoring divide step: shift in the next dividend bit and try a subtract.
   assign rem_shift = {rem_ff, quo_ff[DATA_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, sum_ff});
   always_comb begin
      rem_in = rem_ge ? SUM_W'(rem_shift - {1'b0, sum_ff}) : rem_shift[SUM_W-1:0];
      quo_in = {quo_ff[DATA_W-2:0], rem_ge};
   end

   assign norm = sat_ff ? NORM_SAT : quo_ff;

   // Threshold search followed by descent while values keep dropping.
   always_comb begin
      phase_in     = phase_ff;
      best_lag_in  = best_lag_ff;
      best_norm_in = best_norm_ff;
      unique case (phase_ff)
         PH_SEARCHING: begin
            if (norm < {{(DATA_W - THRESH_W){1'b0}}, thresh_ff}) begin
               phase_in     = PH_DESCENDING;
               best_lag_in  = cur_lag_ff;
               best_norm_in = norm;
            end
         end
         PH_DESCENDING: begin
            if (norm < best_norm_ff) begin
               best_lag_in  = cur_lag_ff;
               best_norm_in = norm;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   // Threshold register.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_write_enable) begin
         thresh_ff <= csr_write_data;
      end
   end

   // Frame state: lag counter, running sum and search progress.
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         lag_cnt_ff   <= '0;
         sum_ff       <= '0;
         phase_ff     <= PH_SEARCHING;
         best_lag_ff  <= '0;
         best_norm_ff <= NORM_SAT;
      end else begin
         if (cmd.load && active) begin
            lag_cnt_ff <= lag_cnt_ff + 1'b1;
            if (lag_cnt_ff != '0) begin
               sum_ff <= sum_in;
            end
         end
         if (cmd.eval) begin
            phase_ff     <= phase_in;
            best_lag_ff  <= best_lag_in;
            best_norm_ff <= best_norm_in;
         end
      end
   end

   // Per-request registers and the divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         need_div_ff <= 1'b0;
         last_ff     <= 1'b0;
      end else if (cmd.load) begin
         need_div_ff <= active && (lag_cnt_ff >= CNT_W'(2));
         last_ff     <= req_last_lag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_lag_ff <= lag_cnt_ff[LAG_W-1:0];
         prod_ff    <= PROD_W'(lag_cnt_ff[LAG_W-1:0] * req_difference_value);
      end
      if (cmd.check) begin
         sat_ff <= overflow;
         rem_ff <= {{(SUM_W - (PROD_W - FRAC_W)){1'b0}}, prod_ff[PROD_W-1:FRAC_W]};
         quo_ff <= {prod_ff[FRAC_W-1:0], {(DATA_W - FRAC_W){1'b0}}};
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // Result register; a waiting result holds up only the final request of a frame, not the others.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff <= (phase_ff != PH_SEARCHING);
         rsp_lag_ff   <= (phase_ff != PH_SEARCHING) ? best_lag_ff : '0;
         rsp_norm_ff  <= (phase_ff != PH_SEARCHING) ? best_norm_ff : '0;
      end
   end

   assign status.need_div = need_div_ff;
   assign status.overflow = overflow;
   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_lag        = rsp_lag_ff;
   assign rsp_norm_value = rsp_norm_ff;

endmodule

/* rtl/yin_cmnd_threshold_lag.sv */
// Top level of the YIN normalized-difference threshold block.
// Instantiates ycmnd_ctrl and ycmnd_dp; depends on ycmnd_pkg.
//
// Feed one difference value per lag, starting at lag 0, and mark the final lag
// of each frame with req_last_lag; one result (found, lag, Q16.16 value) comes
// out per frame and the frame state then clears. Each request for lags 2 through
// 1023 goes through the restoring divider that forms lag*d/sum one quotient bit
// per cycle; a request at lag 0 or 1, past the last supported lag, or with a
// saturated quotient skips the divide steps. The final request of a frame also
// loads the result register, and waits while an earlier result is still there.
// The threshold may be written any time the block is idle.
module yin_cmnd_threshold_lag
   import ycmnd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [DATA_W-1:0]   req_difference_value,
   input  logic                req_last_lag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic [LAG_W-1:0]    rsp_lag,
   output logic [DATA_W-1:0]   rsp_norm_value,
   input  logic                csr_write_enable,
   input  logic [THRESH_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   ycmnd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, search state and result register.
   ycmnd_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_difference_value (req_difference_value),
      .req_last_lag         (req_last_lag),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_lag              (rsp_lag),
      .rsp_norm_value       (rsp_norm_value)
   );

endmodule

/* tb/tb_yin_cmnd_threshold_lag.sv */
// Self-checking testbench for yin_cmnd_threshold_lag: frames of difference values in, one
// lag pick per frame out, checked against a cycle-free predictor in a scoreboard class.
// Depends on ycmnd_pkg and the yin_cmnd_threshold_lag RTL.
module tb_yin_cmnd_threshold_lag
   import ycmnd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned       QUIET_LIMIT     = 20000;
   localparam int unsigned       HOLD_OFF_CYCLES = 600;
   localparam int unsigned       SETTLE_CYCLES   = 64;
   localparam int unsigned       LONG_DIP_AT     = MAX_LAGS - 24;
   localparam logic [DATA_W-1:0] UNITY_Q16       = 32'h0001_0000;

   // How the values of one frame are laid out.
   typedef enum int unsigned {
      SHAPE_DIP,
      SHAPE_NOISE,
      SHAPE_ZERO,
      SHAPE_SHORT,
      SHAPE_LONG
   } frame_shape_type;

   // One expected lag pick.
   typedef struct packed {
      logic              found;
      logic [LAG_W-1:0]  lag;
      logic [DATA_W-1:0] norm;
   } pitch_pick_type;

   // Scoreboard: tracks the frame state of the block and queues the pick of each frame.
   class lag_pick_scoreboard;
      logic [THRESH_W-1:0] threshold = THRESH_RESET;
      int unsigned         next_lag;
      logic [63:0]         lag_sum;
      phase_type           phase;
      logic [LAG_W-1:0]    cand_lag;
      logic [DATA_W-1:0]   cand_norm;
      pitch_pick_type      expected_picks[$];
      int                  mismatches = 0;

      function new();
         clear_frame();
      endfunction

      function void clear_frame();
         next_lag  = 0;
         lag_sum   = '0;
         phase     = PH_SEARCHING;
         cand_lag  = '0;
         cand_norm = NORM_SAT;
      endfunction

      // lag*d/sum as Q16.16, truncated; saturates on a zero sum or a large quotient.
      function logic [DATA_W-1:0] normalized(input int unsigned lag,
                                             input logic [DATA_W-1:0] d,
                                             input logic [63:0] sum);
         logic [63:0] num, quot, rem, frac;
         if (sum == 0)
            return NORM_SAT;
         num  = 64'(lag) * 64'(d);
         quot = num / sum;
         if (quot >= 64'h1_0000)
            return NORM_SAT;
         rem  = num % sum;
         frac = (rem << 16) / sum;
         return {quot[15:0], frac[15:0]};
      endfunction

      task report_mismatch(input string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      // Advances the frame state by one accepted request.
      function void note_request(input logic [DATA_W-1:0] d, input logic last);
         logic [DATA_W-1:0] norm;
         pitch_pick_type    pick;
         if (next_lag < MAX_LAGS) begin
            if (next_lag == 0)
               norm = UNITY_Q16;
            else begin
               lag_sum = lag_sum + 64'(d);
               if (lag_sum > 64'(SUM_MAX))
                  lag_sum = 64'(SUM_MAX);
               norm = normalized(next_lag, d, lag_sum);
            end
            if (next_lag >= 2) begin
               unique case (phase)
                  PH_SEARCHING: begin
                     if (norm < {16'b0, threshold}) begin
                        phase     = PH_DESCENDING;
                        cand_lag  = LAG_W'(next_lag);
                        cand_norm = norm;
                     end
                  end
                  PH_DESCENDING: begin
                     if (norm < cand_norm) begin
                        cand_lag  = LAG_W'(next_lag);
                        cand_norm = norm;
                     end else
                        phase = PH_DONE;
                  end
                  default: ;
               endcase
            end
            next_lag++;
         end
         if (last) begin
            pick.found = (phase != PH_SEARCHING);
            pick.lag   = pick.found ? cand_lag : '0;
            pick.norm  = pick.found ? cand_norm : '0;
            expected_picks = {expected_picks, pick};
            clear_frame();
         end
      endfunction

      // Compares one accepted result with the oldest expected pick.
      task check_result(input logic found, input logic [LAG_W-1:0] lag,
                        input logic [DATA_W-1:0] norm);
         pitch_pick_type want;
         if (expected_picks.size() == 0) begin
            report_mismatch($sformatf("result with none expected: found=%b lag=%0d norm=%h",
                                      found, lag, norm));
            return;
         end
         want = expected_picks.pop_front();
         if (found !== want.found)
            report_mismatch($sformatf("found %b, wanted %b", found, want.found));
         if (lag !== want.lag)
            report_mismatch($sformatf("lag %0d, wanted %0d", lag, want.lag));
         if (norm !== want.norm)
            report_mismatch($sformatf("norm_value %h, wanted %h", norm, want.norm));
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [DATA_W-1:0]   req_difference_value;
   logic                req_last_lag;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_found;
   logic [LAG_W-1:0]    rsp_lag;
   logic [DATA_W-1:0]   rsp_norm_value;
   logic                csr_write_enable;
   logic [THRESH_W-1:0] csr_write_data;

   lag_pick_scoreboard board;
   int unsigned        send_idle_pct = 10;
   int unsigned        stall_pct     = 54;
   logic               hold_off_go   = 1'b0;
   int unsigned        quiet_cycles  = 0;

   yin_cmnd_threshold_lag DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_difference_value (req_difference_value),
      .req_last_lag         (req_last_lag),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_found            (rsp_found),
      .rsp_lag              (rsp_lag),
      .rsp_norm_value       (rsp_norm_value),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one request, with random idle cycles ahead of it, and waits until it is taken.
   // Valid stays high after acceptance so back-to-back requests never toggle it.
   task automatic send_request(input logic [DATA_W-1:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_difference_value <= value;
      req_last_lag         <= last;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   // Sends one frame of n_lags requests; the last one carries the end mark.
   task automatic send_frame(input frame_shape_type shape, input int unsigned n_lags);
      logic [DATA_W-1:0] base, value;
      logic [63:0]       dip;
      int unsigned       dip_at, dip_end;
      base = $urandom() >> $urandom_range(0, 31);
      if (shape == SHAPE_LONG)
         base = 32'h0100_0000;
      if (base == 0)
         base = 1;
      dip     = 64'(base >> $urandom_range(1, 5));
      dip_at  = $urandom_range(2, (n_lags > 2) ? n_lags - 1 : 2);
      dip_end = dip_at + $urandom_range(1, 6);
      for (int unsigned lag = 0; lag < n_lags; lag++) begin
         case (shape)
            SHAPE_DIP: begin
               // A stretch near the base, a run of mostly falling small values, then the base again.
               if (lag >= dip_at && lag < dip_end) begin
                  value = dip[DATA_W-1:0];
                  dip   = (dip * $urandom_range(0, 7)) >> 3;
               end else
                  value = base - ($urandom() % (base / 4 + 1));
            end
            SHAPE_NOISE: begin
               value = ($urandom_range(3) == 0) ? DATA_W'($urandom_range(255)) : $urandom();
            end
            SHAPE_ZERO: begin
               // Zero from lag 1 keeps the sum at zero.
               value = (lag == 0) ? $urandom() : '0;
            end
            SHAPE_LONG: begin
               // Steady values, then a steady descent that ends at the last supported lag;
               // requests past it must be ignored.
               if (lag < LONG_DIP_AT)
                  value = base - ($urandom() % (base / 4 + 1));
               else if (lag < MAX_LAGS)
                  value = DATA_W'(64'(base >> 6) * (MAX_LAGS - 1 - lag)
                                  / (MAX_LAGS - LONG_DIP_AT));
               else
                  value = $urandom();
            end
            default: value = $urandom();
         endcase
         send_request(value, lag == n_lags - 1);
      end
   endtask

   // Random frames until about item_goal requests have gone in.
   task automatic run_random_frames(input int unsigned item_goal, input int unsigned max_len);
      int unsigned     sent, pick, n_lags;
      frame_shape_type shape;
      sent = 0;
      while (sent < item_goal) begin
         pick   = $urandom_range(99);
         n_lags = $urandom_range(3, max_len);
         if (pick < 70)
            shape = SHAPE_DIP;
         else if (pick < 85)
            shape = SHAPE_NOISE;
         else if (pick < 92)
            shape = SHAPE_ZERO;
         else begin
            shape  = SHAPE_SHORT;
            n_lags = $urandom_range(1, 2);
         end
         send_frame(shape, n_lags);
         sent += n_lags;
      end
   endtask

   // Waits for every expected pick, then lets the block settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (board.expected_picks.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.threshold = value;
   endtask

   // Result side: random stalls, or one long hold-off when asked for.
   initial begin : receiver
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_go = 1'b0;
         end else
            rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Handshake monitor and watchdog on cycles with nothing accepted.
   always @(posedge clock) begin : monitor
      if (reset)
         quiet_cycles = 0;
      else begin
         quiet_cycles++;
         if (req_valid && !req_stall) begin
            board.note_request(req_difference_value, req_last_lag);
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_result(rsp_found, rsp_lag, rsp_norm_value);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      board = new();
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_difference_value <= '0;
      req_last_lag         <= 1'b0;
      csr_write_enable     <= 1'b0;
      csr_write_data       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // A frame of a single lag reports not found.
      send_request('1, 1'b1);
      // A frame that ends at lag 1 reports not found.
      send_request(32'h0000_1234, 1'b0);
      send_request(32'h8000_0000, 1'b1);
      // Zero sum: every normalized value saturates.
      send_request(32'd5, 1'b0);
      send_request('0, 1'b0);
      send_request('0, 1'b0);
      send_request('0, 1'b1);
      // Dip found at lag 4, one more step down, then a rise ends the descent and
      // the low value after it must not change the pick.
      send_request('1, 1'b0);
      send_request(32'd1000, 1'b0);
      send_request(32'd1000, 1'b0);
      send_request(32'd1000, 1'b0);
      send_request(32'd100, 1'b0);
      send_request(32'd50, 1'b0);
      send_request(32'd60, 1'b0);
      send_request(32'd10, 1'b1);
      // Full-scale values, then a zero found on the last lag itself.
      send_request('0, 1'b0);
      send_request('1, 1'b0);
      send_request('1, 1'b0);
      send_request('0, 1'b1);

      // Sender mostly busy, receiver stalling often.
      run_random_frames(200, 24);
      drain_results();
      write_threshold('1);
      run_random_frames(150, 24);
      drain_results();

      // Sender idling often, receiver mostly ready.
      send_idle_pct = 54;
      stall_pct     = 10;
      write_threshold('0);
      run_random_frames(100, 24);
      drain_results();
      write_threshold(THRESH_W'($urandom()));
      run_random_frames(150, 64);
      drain_results();

      // No idling. Short frames against a long result hold-off fill the block up,
      // then one frame runs past the last supported lag.
      send_idle_pct = 0;
      stall_pct     = 0;
      write_threshold(16'h4000);
      hold_off_go = 1'b1;
      run_random_frames(100, 4);
      send_frame(SHAPE_LONG, MAX_LAGS + 6);
      drain_results();
      write_threshold(THRESH_RESET);
      run_random_frames(100, 24);
      drain_results();

      if (board.expected_picks.size() != 0)
         board.report_mismatch($sformatf("%0d picks never arrived",
                                         board.expected_picks.size()));
      if (board.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
